>>> hw/rtl/cts_pkg.sv
`timescale 1ns / 1ps

package cts_pkg;

    localparam int MAX_TERMS_DEF = 64;
    localparam int FRAC_BITS_DEF = 28;

    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;
    localparam int EPS_W    = 29;
    localparam int CNT_W    = 7;
    localparam int TERM_W   = 47;
    localparam int SUM_W    = 48;
    localparam int AX_W     = 32;
    localparam int X2_W     = 63;
    localparam int PP_W     = 64;
    localparam int PROD_W   = TERM_W + X2_W;
    localparam int QW       = 48;
    localparam int RADIX    = 8;
    localparam int DIV_CYC  = QW / RADIX;

    localparam logic [TERM_W-1:0] TERM_MAX = {TERM_W{1'b1}};

    localparam logic [EPS_W-1:0] EPS_RST = EPS_W'(268);
    localparam logic [CNT_W-1:0] MT_RST  = CNT_W'(16);

    localparam logic REG_EPSILON   = 1'b0;
    localparam logic REG_MAX_TERMS = 1'b1;

    typedef struct packed {
        logic       start;
        logic       sq;
        logic       add;
        logic       hit;
        logic       adv;
        logic       mul_en;
        logic [1:0] mul_idx;
        logic       acc_en;
        logic       acc_clr;
        logic       sat_load;
        logic       div_init;
        logic       div_step;
        logic       div_last;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic gt_eps;
        logic at_lim;
        logic sat;
    } t_sts;

endpackage

>>> hw/rtl/cosine_taylor_series_top.sv
`timescale 1ns / 1ps

// channel   dir  handshake                    payload
// in        in   i_in_valid / o_in_ready      i_angle
// out       out  o_out_valid / i_out_ready    o_cos_value, o_term_count, o_limit_hit
// config    in   psel, penable, pwrite        paddr, pwdata, prdata, pready
//
// one word at a time, from accept to result; n is the returned term count
// each term: a test, the partial products on the 32x32 multiplier, an accumulate, an overflow check
// and radix-256 division by (2n-1)(2n); a saturated term skips the division
// a finished result waits in the output register while the next word is accepted
// the next result then stalls until the output word is taken
// synchronous active-low reset; registers return to epsilon 268, max_terms 16

module cosine_taylor_series_top
    import cts_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [AX_W-1:0]   i_angle,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_cos_value,
    output logic [CNT_W-1:0]         o_term_count,
    output logic                     o_limit_hit,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    logic [EPS_W-1:0] w_epsilon;
    logic [CNT_W-1:0] w_max_terms;
    t_cmd             w_cmd;
    t_sts             w_sts;

    cts_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_epsilon   (w_epsilon),
        .o_max_terms (w_max_terms)
    );

    cts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    cts_dp #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_angle      (i_angle),
        .i_epsilon    (w_epsilon),
        .i_max_terms  (w_max_terms),
        .o_cos_value  (o_cos_value),
        .o_term_count (o_term_count),
        .o_limit_hit  (o_limit_hit)
    );

endmodule

>>> hw/rtl/cts_regs.sv
`timescale 1ns / 1ps

module cts_regs
    import cts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [EPS_W-1:0]  o_epsilon,
    output logic [CNT_W-1:0]  o_max_terms
);

    logic [EPS_W-1:0] r_epsilon;
    logic [CNT_W-1:0] r_max_terms;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epsilon   <= EPS_RST;
            r_max_terms <= MT_RST;
        end else if (w_wr) begin
            case (paddr[2])
                REG_EPSILON:   r_epsilon   <= pwdata[EPS_W-1:0];
                REG_MAX_TERMS: r_max_terms <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_EPSILON:   prdata = DATA_W'(r_epsilon);
            REG_MAX_TERMS: prdata = DATA_W'(r_max_terms);
            default:       prdata = '0;
        endcase
    end

    assign o_epsilon   = r_epsilon;
    assign o_max_terms = r_max_terms;

endmodule

>>> hw/rtl/cts_ctrl.sv
`timescale 1ns / 1ps

module cts_ctrl
    import cts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int CW = ($clog2(DIV_CYC) > 2) ? $clog2(DIV_CYC) : 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_TEST,
        S_MUL,
        S_ACC,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_TEST;
            end
            S_TEST: begin
                if (i_sts.gt_eps) begin
                    o_cmd.add = 1'b1;
                    if (i_sts.at_lim) begin
                        o_cmd.hit = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        o_cmd.adv = 1'b1;
                        n_cnt     = '0;
                        n_state   = S_MUL;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_idx = r_cnt[1:0];
                o_cmd.acc_en  = (r_cnt != '0);
                o_cmd.acc_clr = (r_cnt == CW'(1));
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == CW'(3)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = S_PREP;
            end
            S_PREP: begin
                n_cnt = '0;
                if (i_sts.sat) begin
                    o_cmd.sat_load = 1'b1;
                    n_state        = S_TEST;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_CYC - 1)) begin
                    o_cmd.div_last = 1'b1;
                    n_state        = S_TEST;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a word not yet taken");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid)
        else $error("loaded result not presented");

    a_accept_sq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SQ))
        else $error("accepted word did not start work");

    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < CW'(DIV_CYC)))
        else $error("divider step count out of range");
`endif

endmodule

>>> hw/rtl/cts_dp.sv
`timescale 1ns / 1ps

module cts_dp
    import cts_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic signed [AX_W-1:0]   i_angle,
    input  logic [EPS_W-1:0]         i_epsilon,
    input  logic [CNT_W-1:0]         i_max_terms,
    output logic signed [DATA_W-1:0] o_cos_value,
    output logic [CNT_W-1:0]         o_term_count,
    output logic                     o_limit_hit
);

    localparam int NW    = $clog2(MAX_TERMS + 1);
    localparam int LW    = (NW > CNT_W) ? NW : CNT_W;
    localparam int D_MAX = (2 * MAX_TERMS - 1) * (2 * MAX_TERMS);
    localparam int DW    = $clog2(D_MAX + 1);
    localparam int SH    = 2 * FRAC_BITS;
    localparam logic [TERM_W-1:0] ONE =
        (FRAC_BITS >= TERM_W) ? TERM_MAX : TERM_W'(64'd1 << FRAC_BITS);

    logic [AX_W-1:0]          r_ax;
    logic [X2_W-1:0]          r_x2;
    logic [TERM_W-1:0]        r_mag;
    logic                     r_neg;
    logic signed [SUM_W-1:0]  r_sum;
    logic [NW-1:0]            r_n;
    logic                     r_hit;
    logic [DW-1:0]            r_d;
    logic [PP_W-1:0]          r_pp;
    logic [1:0]               r_pp_sh;
    logic [PROD_W-1:0]        r_acc;
    logic [DW-1:0]            r_rem;
    logic [QW-1:0]            r_q;
    logic signed [DATA_W-1:0] r_cos;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_lim_hit;

    logic [AX_W-1:0]   w_ax;
    logic [PP_W-1:0]   w_sq;
    logic [31:0]       w_ma;
    logic [31:0]       w_xb;
    logic [PP_W-1:0]   w_pp;
    logic [PROD_W-1:0] w_pp_ext;
    logic [PROD_W-1:0] w_acc_base;
    logic [PROD_W-1:0] w_s;
    logic [NW-1:0]     w_n1;
    logic [NW:0]       w_two_n;
    logic [2*NW+1:0]   w_d_full;
    logic [LW-1:0]     w_lim;
    logic [SUM_W:0]    w_mag_ext;
    logic [SUM_W:0]    w_sum_ext;
    logic [SUM_W-1:0]  w_sum_sat;
    logic [SUM_W-32:0] w_hi;
    logic [DATA_W-1:0] w_cos;
    logic [DW-1:0]     w_rem_nx;
    logic [QW-1:0]     w_q_nx;

    assign w_ax = i_angle[AX_W-1] ? (~i_angle + 1'b1) : i_angle;
    assign w_sq = PP_W'(r_ax) * PP_W'(r_ax);

    // 32x32 partial products of mag * x^2
    assign w_ma = i_cmd.mul_idx[0] ? 32'(r_mag >> 32) : r_mag[31:0];
    assign w_xb = i_cmd.mul_idx[1] ? 32'(r_x2 >> 32) : r_x2[31:0];
    assign w_pp = PP_W'(w_ma) * PP_W'(w_xb);

    always_comb begin
        case (r_pp_sh)
            2'd0:    w_pp_ext = PROD_W'(r_pp);
            2'd1:    w_pp_ext = PROD_W'(r_pp) << 32;
            2'd2:    w_pp_ext = PROD_W'(r_pp) << 64;
            default: w_pp_ext = '0;
        endcase
    end

    assign w_acc_base = i_cmd.acc_clr ? '0 : r_acc;
    assign w_s        = r_acc >> SH;

    // divisor (2n-1)(2n) for the next n
    assign w_n1     = r_n + 1'b1;
    assign w_two_n  = {w_n1, 1'b0};
    assign w_d_full = (2 * NW + 2)'(w_two_n - 1'b1) * (2 * NW + 2)'(w_two_n);

    assign w_lim = (LW'(i_max_terms) > LW'(MAX_TERMS)) ? LW'(MAX_TERMS) : LW'(i_max_terms);

    assign o_sts.gt_eps = r_mag > TERM_W'(i_epsilon);
    assign o_sts.at_lim = LW'(r_n) >= w_lim;
    assign o_sts.sat    = w_s[PROD_W-1:TERM_W] >= (PROD_W - TERM_W)'(r_d);

    // saturating sum
    assign w_mag_ext = (SUM_W + 1)'(r_mag);
    assign w_sum_ext = {r_sum[SUM_W-1], r_sum} + (r_neg ? (~w_mag_ext + 1'b1) : w_mag_ext);

    always_comb begin
        if (w_sum_ext[SUM_W] == w_sum_ext[SUM_W-1]) begin
            w_sum_sat = w_sum_ext[SUM_W-1:0];
        end else if (w_sum_ext[SUM_W]) begin
            w_sum_sat = {1'b1, {(SUM_W - 1){1'b0}}};
        end else begin
            w_sum_sat = {1'b0, {(SUM_W - 1){1'b1}}};
        end
    end

    assign w_hi = r_sum[SUM_W-1:31];

    always_comb begin
        if ((&w_hi) || !(|w_hi)) begin
            w_cos = r_sum[DATA_W-1:0];
        end else if (r_sum[SUM_W-1]) begin
            w_cos = {1'b1, {(DATA_W - 1){1'b0}}};
        end else begin
            w_cos = {1'b0, {(DATA_W - 1){1'b1}}};
        end
    end

    // radix-256 long division, remainder stays below the divisor
    always_comb begin
        logic [DW:0] v_rem_ext;
        logic        v_ge;
        logic [DW-1:0] v_rem;
        logic [QW-1:0] v_q;
        v_rem = r_rem;
        v_q   = r_q;
        for (int k = 0; k < RADIX; k++) begin
            v_rem_ext = {v_rem, v_q[QW-1]};
            v_ge      = v_rem_ext >= {1'b0, r_d};
            v_q       = {v_q[QW-2:0], v_ge};
            v_rem     = v_ge ? DW'(v_rem_ext - {1'b0, r_d}) : DW'(v_rem_ext);
        end
        w_rem_nx = v_rem;
        w_q_nx   = v_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ax  <= w_ax;
            r_mag <= ONE;
            r_neg <= 1'b0;
            r_sum <= '0;
            r_n   <= '0;
            r_hit <= 1'b0;
        end
        if (i_cmd.sq) begin
            r_x2 <= w_sq[X2_W-1:0];
        end
        if (i_cmd.add) begin
            r_sum <= w_sum_sat;
        end
        if (i_cmd.hit) begin
            r_hit <= 1'b1;
        end
        if (i_cmd.adv) begin
            r_n <= w_n1;
            r_d <= DW'(w_d_full);
        end
        if (i_cmd.mul_en) begin
            r_pp    <= w_pp;
            r_pp_sh <= {1'b0, i_cmd.mul_idx[0]} + {1'b0, i_cmd.mul_idx[1]};
        end
        if (i_cmd.acc_en) begin
            r_acc <= w_acc_base + w_pp_ext;
        end
        if (i_cmd.sat_load) begin
            r_mag <= TERM_MAX;
            r_neg <= ~r_neg;
        end
        if (i_cmd.div_init) begin
            r_rem <= w_s[QW+DW-1:QW];
            r_q   <= w_s[QW-1:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= w_rem_nx;
            r_q   <= w_q_nx;
        end
        if (i_cmd.div_last) begin
            r_mag <= w_q_nx[TERM_W-1:0];
            r_neg <= ~r_neg;
        end
        if (i_cmd.load_out) begin
            r_cos     <= w_cos;
            r_cnt     <= CNT_W'(r_n);
            r_lim_hit <= r_hit;
        end
    end

    assign o_cos_value  = r_cos;
    assign o_term_count = r_cnt;
    assign o_limit_hit  = r_lim_hit;

endmodule
